/* rtl/core/isotp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_pkg
// Shared codes, command and status bundles for the response reassembler.
// ----------------------------------------------------------------------------
package isotp_pkg;

	localparam int BUFFER_BYTES = 64;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_FRAME = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [2:0] KIND_FLOW    = 3'd0;
	localparam logic [2:0] KIND_BYTE    = 3'd1;
	localparam logic [2:0] KIND_NEG     = 3'd2;
	localparam logic [2:0] KIND_TIMEOUT = 3'd3;
	localparam logic [2:0] KIND_EMPTY   = 3'd4;

	localparam logic [3:0] PCI_SINGLE = 4'h0;
	localparam logic [3:0] PCI_FIRST  = 4'h1;
	localparam logic [3:0] PCI_CONSEC = 4'h2;

	localparam logic [0:0] REG_REQUEST_ID = 1'b0;
	localparam logic [0:0] REG_TIMEOUT_MS = 1'b1;

	localparam logic [11:0] RESP_ID_OFFSET = 12'h008;
	localparam logic [7:0]  NEG_SID        = 8'h7F;
	localparam logic [7:0]  NRC_PENDING    = 8'h78;
	localparam logic [7:0]  NRC_ABSENT     = 8'hFF;
	localparam logic [7:0]  SVC_ABSENT     = 8'h22;
	localparam logic [15:0] TIMER_MAX      = 16'hFFFF;

	typedef enum logic [1:0] {
		WMODE_SINGLE = 2'd0,
		WMODE_FIRST  = 2'd1,
		WMODE_CONSEC = 2'd2
	} wmode_t;

	typedef struct packed {
		logic       capture;
		logic       clear;
		logic       tick;
		logic       clr_elapsed;
		logic       wr_start;
		wmode_t     wr_mode;
		logic       wr_step;
		logic       rd_start;
		logic       rd_issue;
		logic       rd_next;
		logic       load_res;
		logic [2:0] res_kind;
	} cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       id_match;
		logic [3:0] pci;
		logic       timeout_hit;
		logic       wr_more;
		logic       neg;
		logic       nrc_pending;
		logic       complete;
		logic       total_zero;
		logic       rd_last;
		logic       out_free;
	} status_t;

	function automatic logic [7:0] frame_byte(input logic [63:0] d, input logic [2:0] i);
		return d[8 * (7 - i) +: 8];
	endfunction

endpackage

/* rtl/core/isotp_uds_response_reassembler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_uds_response_reassembler
// Requests are taken one at a time: the next is accepted only once the
// previous one finishes, result stalls included. Frame bytes are written one
// at a time through the single buffer write port, and a delivered message is
// read back from the buffer and sent as one result per byte in place of a
// single result. Reset is asynchronous and clears the wait, reassembly and
// timer state; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module isotp_uds_response_reassembler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [10:0] frame_id,
	input  logic [63:0] frame_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic [5:0]  byte_index,
	output logic [6:0]  message_length,
	output logic [7:0]  service_code,
	output logic [7:0]  nrc_code,
	output logic        last
);

	isotp_pkg::cmd_t    cmd;
	isotp_pkg::status_t status;

	assign cfg_ready = 1'b1;

	isotp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.status    (status),
		.cmd       (cmd)
	);

	isotp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.frame_id      (frame_id),
		.frame_data    (frame_data),
		.result_stall  (result_stall),
		.cmd           (cmd),
		.status        (status),
		.result_valid  (result_valid),
		.kind          (kind),
		.data_byte     (data_byte),
		.byte_index    (byte_index),
		.message_length(message_length),
		.service_code  (service_code),
		.nrc_code      (nrc_code),
		.last          (last)
	);

endmodule

/* rtl/core/isotp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isotp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/isotp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_dp
// Datapath: configuration, frame latch, counters, timer, buffer and result
// register.
// ----------------------------------------------------------------------------
module isotp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [0:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [1:0]          opcode,
	input  logic [10:0]         frame_id,
	input  logic [63:0]         frame_data,
	input  logic                result_stall,
	input  isotp_pkg::cmd_t     cmd,
	output isotp_pkg::status_t  status,
	output logic                result_valid,
	output logic [2:0]          kind,
	output logic [7:0]          data_byte,
	output logic [5:0]          byte_index,
	output logic [6:0]          message_length,
	output logic [7:0]          service_code,
	output logic [7:0]          nrc_code,
	output logic                last
);

	localparam int AW = $clog2(isotp_pkg::BUFFER_BYTES);
	localparam int CW = $clog2(isotp_pkg::BUFFER_BYTES + 1);

	logic [10:0]      request_id_q;
	logic [15:0]      timeout_q;
	logic [1:0]       opcode_q;
	logic [10:0]      fid_q;
	logic [63:0]      data_q;
	logic [11:0]      exp_q;
	logic [CW-1:0]    rc_q;
	logic [15:0]      elapsed_q;
	isotp_pkg::wmode_t mode_q;
	logic [2:0]       k_q;
	logic [2:0]       nmax_q;
	logic [2:0]       off_q;
	logic [7:0]       head0_q;
	logic [7:0]       head1_q;
	logic [7:0]       head2_q;
	logic [AW-1:0]    di_q;
	logic             rv_q;

	logic [7:0]       b0;
	logic [2:0]       sf_len;
	logic [15:0]      elapsed_nx;
	logic             sf_mode;
	logic [11:0]      total;
	logic             neg;
	logic [7:0]       svc;
	logic [7:0]       nrc;
	logic             out_free;
	logic             rd_last;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [7:0]       wdata;
	logic [7:0]       rdata;

	assign b0         = isotp_pkg::frame_byte(data_q, 3'd0);
	assign sf_len     = b0[3] ? 3'd7 : b0[2:0];
	assign elapsed_nx = (elapsed_q == isotp_pkg::TIMER_MAX) ? elapsed_q : elapsed_q + 16'd1;
	assign sf_mode    = (mode_q == isotp_pkg::WMODE_SINGLE);
	assign total      = sf_mode ? 12'(nmax_q) : exp_q;
	assign neg        = (total != 12'd0) && (head0_q == isotp_pkg::NEG_SID);
	assign svc        = (total >= 12'd2) ? head1_q : isotp_pkg::SVC_ABSENT;
	assign nrc        = (total >= 12'd3) ? head2_q : isotp_pkg::NRC_ABSENT;
	assign out_free   = !rv_q || !result_stall;
	assign rd_last    = (12'(di_q) + 12'd1) == total;

	assign we    = cmd.wr_step;
	assign waddr = sf_mode ? AW'(k_q) : rc_q[AW-1:0];
	assign wdata = isotp_pkg::frame_byte(data_q, 3'(off_q + k_q));

	always_comb begin
		status.opcode      = opcode_q;
		status.id_match    = {1'b0, fid_q} == (12'(request_id_q) + isotp_pkg::RESP_ID_OFFSET);
		status.pci         = b0[7:4];
		status.timeout_hit = elapsed_nx >= timeout_q;
		status.wr_more     = (k_q < nmax_q)
			&& (sf_mode || ((12'(rc_q) < exp_q)
			&& (12'(rc_q) < 12'(isotp_pkg::BUFFER_BYTES))));
		status.neg         = neg;
		status.nrc_pending = neg && (nrc == isotp_pkg::NRC_PENDING);
		status.complete    = 12'(rc_q) >= exp_q;
		status.total_zero  = (total == 12'd0);
		status.rd_last     = rd_last;
		status.out_free    = out_free;
	end

	isotp_ram #(
		.WIDTH(8),
		.DEPTH(isotp_pkg::BUFFER_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_issue),
		.raddr(di_q),
		.rdata(rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_id_q <= 11'd2016;
			timeout_q    <= 16'd150;
		end else if (cfg_valid) begin
			case (cfg_index)
				isotp_pkg::REG_REQUEST_ID: request_id_q <= cfg_data[10:0];
				isotp_pkg::REG_TIMEOUT_MS: timeout_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q  <= '0;
			fid_q     <= '0;
			data_q    <= '0;
			exp_q     <= '0;
			rc_q      <= '0;
			elapsed_q <= '0;
			mode_q    <= isotp_pkg::WMODE_SINGLE;
			k_q       <= '0;
			nmax_q    <= '0;
			off_q     <= '0;
			head0_q   <= '0;
			head1_q   <= '0;
			head2_q   <= '0;
			di_q      <= '0;
		end else begin
			if (cmd.capture) begin
				opcode_q <= opcode;
				fid_q    <= frame_id;
				data_q   <= frame_data;
			end
			if (cmd.clear) begin
				exp_q     <= '0;
				rc_q      <= '0;
				elapsed_q <= '0;
			end
			if (cmd.tick) begin
				elapsed_q <= elapsed_nx;
			end
			if (cmd.clr_elapsed) begin
				elapsed_q <= '0;
			end
			if (cmd.wr_start) begin
				mode_q <= cmd.wr_mode;
				k_q    <= '0;
				case (cmd.wr_mode)
					isotp_pkg::WMODE_SINGLE: begin
						nmax_q <= sf_len;
						off_q  <= 3'd1;
					end
					isotp_pkg::WMODE_FIRST: begin
						exp_q  <= {b0[3:0], isotp_pkg::frame_byte(data_q, 3'd1)};
						rc_q   <= '0;
						nmax_q <= 3'd6;
						off_q  <= 3'd2;
					end
					default: begin
						nmax_q <= 3'd7;
						off_q  <= 3'd1;
					end
				endcase
			end
			if (cmd.wr_step) begin
				k_q <= k_q + 3'd1;
				if (!sf_mode) begin
					rc_q <= rc_q + CW'(1);
				end
				if (waddr == AW'(0)) head0_q <= wdata;
				if (waddr == AW'(1)) head1_q <= wdata;
				if (waddr == AW'(2)) head2_q <= wdata;
			end
			if (cmd.rd_start) begin
				di_q <= '0;
			end
			if (cmd.rd_next) begin
				di_q <= di_q + AW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q           <= 1'b0;
			kind           <= '0;
			data_byte      <= '0;
			byte_index     <= '0;
			message_length <= '0;
			service_code   <= '0;
			nrc_code       <= '0;
			last           <= 1'b0;
		end else if (cmd.load_res) begin
			rv_q           <= 1'b1;
			kind           <= cmd.res_kind;
			data_byte      <= '0;
			byte_index     <= '0;
			message_length <= '0;
			service_code   <= '0;
			nrc_code       <= '0;
			last           <= 1'b1;
			if (cmd.res_kind == isotp_pkg::KIND_BYTE) begin
				data_byte      <= rdata;
				byte_index     <= 6'(di_q);
				message_length <= 7'(total);
				last           <= rd_last;
			end
			if (cmd.res_kind == isotp_pkg::KIND_NEG) begin
				service_code <= svc;
				nrc_code     <= nrc;
			end
		end else if (!result_stall) begin
			rv_q <= 1'b0;
		end
	end

	assign result_valid = rv_q;

endmodule

/* rtl/core/isotp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_ctrl
// Controller: wait and reassembly flags, frame classification and sequencing
// of buffer writes and message delivery.
// ----------------------------------------------------------------------------
module isotp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  isotp_pkg::status_t status,
	output isotp_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLASS = 7'b0000010,
		ST_WRITE = 7'b0000100,
		ST_POST  = 7'b0001000,
		ST_EMIT  = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_SEND  = 7'b1000000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic              waiting_q;
	logic              waiting_d;
	logic              assembling_q;
	logic              assembling_d;
	logic [2:0]        kind_q;
	logic [2:0]        kind_d;
	isotp_pkg::wmode_t mode_q;
	isotp_pkg::wmode_t mode_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d      = state_q;
		waiting_d    = waiting_q;
		assembling_d = assembling_q;
		kind_d       = kind_q;
		mode_d       = mode_q;
		cmd          = '0;
		cmd.res_kind = kind_q;
		cmd.wr_mode  = mode_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CLASS;
				end
			end
			ST_CLASS: begin
				state_d = ST_IDLE;
				case (status.opcode)
					isotp_pkg::OP_START: begin
						waiting_d    = 1'b1;
						assembling_d = 1'b0;
						cmd.clear    = 1'b1;
					end
					isotp_pkg::OP_TICK: begin
						if (waiting_q) begin
							cmd.tick = 1'b1;
							if (status.timeout_hit) begin
								waiting_d    = 1'b0;
								assembling_d = 1'b0;
								kind_d       = isotp_pkg::KIND_TIMEOUT;
								state_d      = ST_EMIT;
							end
						end
					end
					isotp_pkg::OP_FRAME: begin
						if (waiting_q && status.id_match) begin
							case (status.pci)
								isotp_pkg::PCI_SINGLE: begin
									mode_d = isotp_pkg::WMODE_SINGLE;
									state_d = ST_WRITE;
								end
								isotp_pkg::PCI_FIRST: begin
									mode_d = isotp_pkg::WMODE_FIRST;
									state_d = ST_WRITE;
								end
								isotp_pkg::PCI_CONSEC: begin
									if (assembling_q) begin
										mode_d = isotp_pkg::WMODE_CONSEC;
										state_d = ST_WRITE;
									end
								end
								default: ;
							endcase
							cmd.wr_start = (state_d == ST_WRITE);
							cmd.wr_mode  = mode_d;
						end
					end
					default: ;
				endcase
			end
			ST_WRITE: begin
				if (status.wr_more) begin
					cmd.wr_step = 1'b1;
				end else begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				state_d = ST_IDLE;
				case (mode_q)
					isotp_pkg::WMODE_SINGLE: begin
						if (status.nrc_pending) begin
							cmd.clr_elapsed = 1'b1;
						end else begin
							waiting_d    = 1'b0;
							assembling_d = 1'b0;
							if (status.neg) begin
								kind_d  = isotp_pkg::KIND_NEG;
								state_d = ST_EMIT;
							end else if (status.total_zero) begin
								kind_d  = isotp_pkg::KIND_EMPTY;
								state_d = ST_EMIT;
							end else begin
								cmd.rd_start = 1'b1;
								state_d      = ST_READ;
							end
						end
					end
					isotp_pkg::WMODE_FIRST: begin
						assembling_d = 1'b1;
						kind_d       = isotp_pkg::KIND_FLOW;
						state_d      = ST_EMIT;
					end
					default: begin
						if (status.complete) begin
							waiting_d    = 1'b0;
							assembling_d = 1'b0;
							if (status.neg) begin
								kind_d  = isotp_pkg::KIND_NEG;
								state_d = ST_EMIT;
							end else if (status.total_zero) begin
								kind_d  = isotp_pkg::KIND_EMPTY;
								state_d = ST_EMIT;
							end else begin
								cmd.rd_start = 1'b1;
								state_d      = ST_READ;
							end
						end
					end
				endcase
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_res = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_SEND;
			end
			ST_SEND: begin
				if (status.out_free) begin
					cmd.load_res = 1'b1;
					cmd.res_kind = isotp_pkg::KIND_BYTE;
					if (status.rd_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
						state_d     = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			waiting_q    <= 1'b0;
			assembling_q <= 1'b0;
			kind_q       <= isotp_pkg::KIND_FLOW;
			mode_q       <= isotp_pkg::WMODE_SINGLE;
		end else begin
			state_q      <= state_d;
			waiting_q    <= waiting_d;
			assembling_q <= assembling_d;
			kind_q       <= kind_d;
			mode_q       <= mode_d;
		end
	end

endmodule

/* bench/isotp_uds_response_reassembler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_uds_response_reassembler_test
// Drives start, frame, tick and reserved requests through the reassembler in
// bursts, tracks the reply it should produce with a behavioural copy of the
// reassembly state, and compares every result field against it in order.
// ----------------------------------------------------------------------------
module isotp_uds_response_reassembler_test;

	localparam int         BUF_BYTES   = isotp_pkg::BUFFER_BYTES;
	localparam int         IDLE_LIMIT  = 4000;
	localparam int         LONG_HOLD   = 300;
	localparam int         SETTLE      = 40;
	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam logic [3:0] PCI_FLOW    = 4'h3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [10:0] frame_id;
		logic [63:0] frame_data;
	} request_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic [5:0] byte_index;
		logic [6:0] message_length;
		logic [7:0] service_code;
		logic [7:0] nrc_code;
		logic       last;
	} reply_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index    = isotp_pkg::REG_REQUEST_ID;
	logic [15:0] cfg_data     = '0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	logic [1:0]  opcode       = isotp_pkg::OP_START;
	logic [10:0] frame_id     = '0;
	logic [63:0] frame_data   = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic [5:0]  byte_index;
	logic [6:0]  message_length;
	logic [7:0]  service_code;
	logic [7:0]  nrc_code;
	logic        last;

	request_t request_queue[$];
	reply_t   pending_replies[$];
	request_t on_wire;
	int       failures     = 0;
	int       requests_made = 0;
	int       idle_cycles  = 0;
	int       burst_left   = 0;
	int       gap_left     = 0;
	int       hold_left    = 0;
	int       holds_asked  = 0;
	int       holds_served = 0;
	int       pattern_left = 0;
	int       stall_pct    = 0;

	// reassembly state and register copies
	bit          waiting_rsp   = 1'b0;
	bit          assembling    = 1'b0;
	int unsigned announced_len = 0;
	int unsigned stored_count  = 0;
	int unsigned elapsed_ms    = 0;
	logic [7:0]  rx_buffer [BUF_BYTES];
	logic [10:0] request_id_reg = 11'd2016;
	logic [15:0] timeout_reg    = 16'd150;

	isotp_uds_response_reassembler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.frame_id(frame_id),
		.frame_data(frame_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.message_length(message_length),
		.service_code(service_code),
		.nrc_code(nrc_code),
		.last(last)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] payload_byte(input logic [63:0] d, input int i);
		return d[8 * (7 - i) +: 8];
	endfunction

	function automatic reply_t make_reply(input logic [2:0] k, input logic [7:0] db,
			input int idx, input int len, input logic [7:0] svc, input logic [7:0] nrc);
		reply_t r;
		r.kind           = k;
		r.data_byte      = db;
		r.byte_index     = 6'(idx);
		r.message_length = 7'(len);
		r.service_code   = svc;
		r.nrc_code       = nrc;
		r.last           = 1'b0;
		return r;
	endfunction

	function automatic logic [10:0] resp_id();
		return 11'(request_id_reg + 11'd8);
	endfunction

	task automatic emit_message(input int unsigned n, ref reply_t batch[$]);
		if (n == 0) begin
			batch.push_back(make_reply(isotp_pkg::KIND_EMPTY, 8'h00, 0, 0, 8'h00, 8'h00));
		end else begin
			for (int i = 0; i < n && i < BUF_BYTES; i++)
				batch.push_back(make_reply(isotp_pkg::KIND_BYTE, rx_buffer[i], i, n,
					8'h00, 8'h00));
		end
	endtask

	task automatic end_wait();
		waiting_rsp = 1'b0;
		assembling  = 1'b0;
	endtask

	task automatic reassemble(input request_t rq);
		reply_t      batch[$];
		logic [7:0]  b0;
		logic [7:0]  svc;
		logic [7:0]  nrc;
		int unsigned len;
		int          k;
		b0 = payload_byte(rq.frame_data, 0);
		case (rq.opcode)
		isotp_pkg::OP_START: begin
			waiting_rsp   = 1'b1;
			assembling    = 1'b0;
			announced_len = 0;
			stored_count  = 0;
			elapsed_ms    = 0;
		end
		isotp_pkg::OP_TICK: begin
			if (waiting_rsp) begin
				if (elapsed_ms < isotp_pkg::TIMER_MAX)
					elapsed_ms++;
				if (elapsed_ms >= timeout_reg) begin
					end_wait();
					batch.push_back(make_reply(isotp_pkg::KIND_TIMEOUT, 8'h00, 0, 0,
						8'h00, 8'h00));
				end
			end
		end
		isotp_pkg::OP_FRAME: begin
			if (waiting_rsp && {1'b0, rq.frame_id} ==
					{1'b0, request_id_reg} + isotp_pkg::RESP_ID_OFFSET) begin
				case (b0[7:4])
				isotp_pkg::PCI_SINGLE: begin
					len = (b0[3:0] > 7) ? 7 : b0[3:0];
					for (k = 0; k < len; k++)
						rx_buffer[k] = payload_byte(rq.frame_data, k + 1);
					if (len >= 1 && rx_buffer[0] == isotp_pkg::NEG_SID) begin
						nrc = (len >= 3) ? rx_buffer[2] : isotp_pkg::NRC_ABSENT;
						svc = (len >= 2) ? rx_buffer[1] : isotp_pkg::SVC_ABSENT;
						if (nrc == isotp_pkg::NRC_PENDING) begin
							elapsed_ms = 0;
						end else begin
							end_wait();
							batch.push_back(make_reply(isotp_pkg::KIND_NEG, 8'h00, 0, 0,
								svc, nrc));
						end
					end else begin
						end_wait();
						emit_message(len, batch);
					end
				end
				isotp_pkg::PCI_FIRST: begin
					announced_len = {b0[3:0], payload_byte(rq.frame_data, 1)};
					stored_count  = 0;
					for (k = 0; k < 6 && stored_count < announced_len &&
							stored_count < BUF_BYTES; k++) begin
						rx_buffer[stored_count] = payload_byte(rq.frame_data, k + 2);
						stored_count++;
					end
					assembling = 1'b1;
					batch.push_back(make_reply(isotp_pkg::KIND_FLOW, 8'h00, 0, 0,
						8'h00, 8'h00));
				end
				isotp_pkg::PCI_CONSEC: begin
					if (assembling) begin
						for (k = 0; k < 7 && stored_count < announced_len &&
								stored_count < BUF_BYTES; k++) begin
							rx_buffer[stored_count] = payload_byte(rq.frame_data, k + 1);
							stored_count++;
						end
						if (stored_count >= announced_len) begin
							end_wait();
							if (announced_len >= 1 && rx_buffer[0] == isotp_pkg::NEG_SID) begin
								svc = (announced_len >= 2) ? rx_buffer[1] :
									isotp_pkg::SVC_ABSENT;
								nrc = (announced_len >= 3) ? rx_buffer[2] :
									isotp_pkg::NRC_ABSENT;
								batch.push_back(make_reply(isotp_pkg::KIND_NEG, 8'h00, 0, 0,
									svc, nrc));
							end else begin
								emit_message((announced_len < BUF_BYTES) ? announced_len :
									BUF_BYTES, batch);
							end
						end
					end
				end
				default: ;
				endcase
			end
		end
		default: ;
		endcase
		if (batch.size() > 0) begin
			batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				pending_replies.push_back(batch[i]);
		end
	endtask

	// request driver, bursts with random gaps
	always @(posedge clk) begin
		if (arst_n && !(item_valid && item_stall)) begin
			if (item_valid)
				reassemble(on_wire);
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (request_queue.size() > 0) begin
				on_wire = request_queue.pop_front();
				item_valid <= 1'b1;
				opcode     <= on_wire.opcode;
				frame_id   <= on_wire.frame_id;
				frame_data <= on_wire.frame_data;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 15);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (holds_served < holds_asked && item_valid) begin
			hold_left = LONG_HOLD;
			holds_served++;
			result_stall <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(20, 120);
				case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 30;
				default: stall_pct = 75;
				endcase
			end else begin
				pattern_left--;
			end
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected result, kind %0d", kind);
				failures++;
			end else begin
				want = pending_replies.pop_front();
				check_field("kind", want.kind, kind);
				check_field("data_byte", want.data_byte, data_byte);
				check_field("byte_index", want.byte_index, byte_index);
				check_field("message_length", want.message_length, message_length);
				check_field("service_code", want.service_code, service_code);
				check_field("nrc_code", want.nrc_code, nrc_code);
				check_field("last", want.last, last);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic push_request(input logic [1:0] op, input logic [10:0] fid,
			input logic [63:0] d);
		request_t rq;
		rq.opcode     = op;
		rq.frame_id   = fid;
		rq.frame_data = d;
		request_queue.push_back(rq);
		requests_made++;
	endtask

	task automatic frame_in(input logic [63:0] d);
		push_request(isotp_pkg::OP_FRAME, resp_id(), d);
	endtask

	task automatic tick();
		push_request(isotp_pkg::OP_TICK, 11'($urandom), rand64());
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == isotp_pkg::REG_REQUEST_ID)
			request_id_reg = value[10:0];
		else
			timeout_reg = value;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (request_queue.size() != 0 || item_valid || pending_replies.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic add_noise();
		logic [10:0] fid;
		logic [63:0] d;
		d = rand64();
		case ($urandom_range(0, 4))
		0: begin
			fid = 11'($urandom_range(0, 2047));
			if (fid == resp_id())
				fid = fid ^ 11'h001;
			push_request(isotp_pkg::OP_FRAME, fid, d);
		end
		1: begin
			d[63:60] = PCI_FLOW;
			frame_in(d);
		end
		2: begin
			d[63:60] = 4'($urandom_range(4, 15));
			frame_in(d);
		end
		3: push_request(OP_RESERVED, 11'($urandom), d);
		default: tick();
		endcase
	endtask

	task automatic random_session();
		int          pick;
		int          cfs;
		int unsigned len;
		bit          overflow;
		logic [63:0] d;
		push_request(isotp_pkg::OP_START, 11'($urandom), rand64());
		if ($urandom_range(0, 3) == 0)
			add_noise();
		pick = $urandom_range(0, 9);
		case (pick)
		0, 1, 2: begin
			d = rand64();
			d[63:60] = isotp_pkg::PCI_SINGLE;
			if ($urandom_range(0, 7) == 0)
				d[55:48] = isotp_pkg::NEG_SID;
			frame_in(d);
		end
		3: begin
			d = rand64();
			d[63:56] = {isotp_pkg::PCI_SINGLE, 4'($urandom_range(1, 3))};
			d[55:48] = isotp_pkg::NEG_SID;
			if ($urandom_range(0, 1))
				d[39:32] = isotp_pkg::NRC_PENDING;
			frame_in(d);
			repeat ($urandom_range(0, 2)) tick();
			d = rand64();
			d[63:60] = isotp_pkg::PCI_SINGLE;
			frame_in(d);
		end
		4, 5, 6, 7: begin
			pick = $urandom_range(0, 9);
			overflow = 1'b0;
			if (pick < 7) begin
				len = $urandom_range(0, 40);
			end else if (pick < 9) begin
				len = $urandom_range(41, 64);
			end else begin
				len = $urandom_range(65, 4095);
				overflow = 1'b1;
			end
			d = rand64();
			d[63:48] = {isotp_pkg::PCI_FIRST, 12'(len)};
			if ($urandom_range(0, 5) == 0)
				d[47:40] = isotp_pkg::NEG_SID;
			frame_in(d);
			if (overflow)
				cfs = $urandom_range(2, 10);
			else
				cfs = (len <= 6) ? 1 : (len - 6 + 6) / 7;
			// sometimes the sender gives up part way
			if ($urandom_range(0, 9) == 0)
				cfs = $urandom_range(0, cfs);
			for (int i = 0; i < cfs; i++) begin
				if ($urandom_range(0, 5) == 0)
					add_noise();
				d = rand64();
				d[63:56] = {isotp_pkg::PCI_CONSEC,
					($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'(i + 1)};
				frame_in(d);
			end
			if (overflow)
				repeat (timeout_reg) tick();
		end
		8: repeat ((timeout_reg > 40) ? 5 : timeout_reg) tick();
		default: repeat (2) add_noise();
		endcase
	endtask

	initial begin
		int          base;
		logic [63:0] d;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: ignored traffic, single frames, short multi-frame replies
		tick();
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		push_request(isotp_pkg::OP_START, 11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF);
		push_request(isotp_pkg::OP_FRAME, 11'h7E0, 64'h0362_F190_0000_0000);
		frame_in(64'h2111_2233_4455_6677);
		frame_in(64'h3000_0000_0000_0000);
		push_request(OP_RESERVED, 11'h7E8, 64'h0362_F190_0000_0000);
		frame_in(64'h0362_F190_AABB_CCDD);
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		frame_in(64'h0000_0000_0000_0000);
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		frame_in(64'h0F11_2233_4455_6677);
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		frame_in(64'h037F_2278_0000_0000);
		tick();
		frame_in(64'h017F_0000_0000_0000);
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		frame_in(64'h037F_2E31_0000_0000);
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		frame_in(64'h1014_62F1_9001_0203);
		frame_in(64'h2104_0506_0708_090A);
		tick();
		frame_in(64'h220B_0C0D_0E0F_1011);
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		frame_in(64'h1003_7F19_7800_0000);
		frame_in(64'h21FF_FFFF_FFFF_FFFF);
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		frame_in(64'h1000_0000_0000_0000);
		frame_in(64'h2155_5555_5555_5555);
		drain();

		// shortest timeout, full buffer and oversize message
		write_reg(isotp_pkg::REG_REQUEST_ID, 16'd0);
		write_reg(isotp_pkg::REG_TIMEOUT_MS, 16'd1);
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		tick();
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		d = rand64();
		frame_in({isotp_pkg::PCI_FIRST, 12'd64, d[47:0]});
		for (int i = 0; i < 9; i++) begin
			d = rand64();
			frame_in({isotp_pkg::PCI_CONSEC, 4'(i + 1), d[55:0]});
		end
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		d = rand64();
		frame_in({isotp_pkg::PCI_FIRST, 12'hFFF, d[47:0]});
		d = rand64();
		frame_in({isotp_pkg::PCI_CONSEC, 4'h1, d[55:0]});
		tick();
		drain();

		// identifier sum past eleven bits never matches
		write_reg(isotp_pkg::REG_REQUEST_ID, 16'd2047);
		write_reg(isotp_pkg::REG_TIMEOUT_MS, 16'hFFFF);
		push_request(isotp_pkg::OP_START, 11'h000, 64'h0);
		frame_in(64'h0362_F190_0000_0000);
		push_request(isotp_pkg::OP_FRAME, 11'h7FF, 64'h0362_F190_0000_0000);
		tick();
		drain();

		for (int p = 0; p < 4; p++) begin
			write_reg(isotp_pkg::REG_REQUEST_ID, 16'($urandom_range(0, 2039)));
			write_reg(isotp_pkg::REG_TIMEOUT_MS, 16'($urandom_range(2, 30)));
			if (p == 1)
				holds_asked++;
			base = requests_made;
			while (requests_made - base < 28)
				random_session();
			drain();
		end

		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
